>>> design/blfid_pkg.sv
// ----------------------------------------------------------------------------
// blfid_pkg: shared definitions for the bounded front-insert list
// Request and status codes, the default capacity and the cell control bundle.
// ----------------------------------------------------------------------------
package blfid_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int DATA_W       = 32;

  // request codes
  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_DELETE = 2'd1;
  localparam logic [1:0] REQ_SEARCH = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_EMPTY   = 2'd1;
  localparam logic [1:0] ST_NOMATCH = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  // per-cell control from the sequencer
  typedef struct packed {
    logic load_left;   // take the neighbor toward the front (insert)
    logic load_right;  // take the neighbor toward the back (delete)
    logic cmp;         // capture the match flag
  } cell_ctrl_t;

endpackage

>>> design/blfid_cell.sv
// ----------------------------------------------------------------------------
// blfid_cell: one storage cell of the list
// Holds one entry, compares it against the broadcast value and shifts toward
// either neighbor on command.
// ----------------------------------------------------------------------------
module blfid_cell import blfid_pkg::*; (
  input  logic              clk,
  input  cell_ctrl_t        ctrl,
  input  logic              active,
  input  logic [DATA_W-1:0] value,
  input  logic [DATA_W-1:0] left_data,
  input  logic [DATA_W-1:0] right_data,
  output logic [DATA_W-1:0] data,
  output logic              hit
);

  logic [DATA_W-1:0] data_r;
  logic [DATA_W-1:0] data_nxt;
  logic              hit_r;
  logic              hit_nxt;

  always_comb begin
    data_nxt = data_r;
    if (ctrl.load_left) begin
      data_nxt = left_data;
    end else if (ctrl.load_right) begin
      data_nxt = right_data;
    end
    // only cells inside the list may report a hit
    hit_nxt = ctrl.cmp ? (active && (data_r == value)) : hit_r;
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    hit_r  <= hit_nxt;
  end

  assign data = data_r;
  assign hit  = hit_r;

endmodule

>>> design/bounded_list_front_insert_delete.sv
// ----------------------------------------------------------------------------
// bounded_list_front_insert_delete: front-insert list with delete and search
// An ordered list of up to CAPACITY 32-bit values held in a row of cells.
// ----------------------------------------------------------------------------
//   channel  direction  handshake              payload
//   in_      input      in_valid / in_ready    in_req_type, in_value
//   out_     output     out_valid / out_ready  out_status, out_found, out_entry_count
//
// Each beat passes through accept, compare in every cell (registered
// match flag per cell), then commit the shift and write the result register.
// The compare step is there because the match flags are registered in the cells.
// Reset clears the entry count and the sequencer; cell contents stay as is.
// A result waiting in the output register does not block the next input
// beat; that beat only holds in its commit step until the result is taken.
// ----------------------------------------------------------------------------
module bounded_list_front_insert_delete import blfid_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               in_req_type,
  input  logic signed [DATA_W-1:0] in_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [1:0]               out_status,
  output logic                     out_found,
  output logic [4:0]               out_entry_count
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int EW = (CW > 5) ? CW : 5;

  typedef enum logic [1:0] {S_IDLE, S_CMP, S_UPD} state_t;

  state_t            state_r, state_nxt;
  logic [1:0]        req_r;
  logic [DATA_W-1:0] value_r;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              out_valid_r;
  logic [1:0]        out_status_r;
  logic              out_found_r;
  logic [CW-1:0]     out_cnt_r;

  logic              commit;
  logic              full;
  logic              empty;
  logic              any_hit;
  logic [1:0]        res_status;
  logic              res_found;

  logic [CAPACITY-1:0] hit_vec;
  logic [CAPACITY-1:0] upto_first;   // bits from the front through the first hit
  logic [CAPACITY-1:0] before_first; // bits strictly ahead of the first hit
  logic [DATA_W-1:0]   cell_data [CAPACITY];
  cell_ctrl_t          cell_ctrl [CAPACITY];
  logic [CAPACITY-1:0] cell_active;
  logic [EW-1:0]       cnt_ext;

  assign full  = (cnt_r == CW'(CAPACITY));
  assign empty = (cnt_r == '0);

  // accept only when the sequencer is free
  assign in_ready = (state_r == S_IDLE);

  // --------------------------------------------------------------------------
  // First-hit isolation: subtracting one flips the trailing zeros and the
  // lowest set bit, so the xor marks everything up to and including it.
  // --------------------------------------------------------------------------
  assign any_hit      = |hit_vec;
  assign upto_first   = hit_vec ^ (hit_vec - CAPACITY'(1));
  assign before_first = upto_first & ~hit_vec;

  // --------------------------------------------------------------------------
  // Cell row
  // --------------------------------------------------------------------------
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] left_d;
    logic [DATA_W-1:0] right_d;

    if (i == 0) begin : g_front
      assign left_d = value_r;
    end else begin : g_mid_l
      assign left_d = cell_data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_back
      assign right_d = cell_data[i];
    end else begin : g_mid_r
      assign right_d = cell_data[i+1];
    end

    assign cell_active[i] = (CW'(i) < cnt_r);

    // insert: whole row moves one place back; delete: cells from the first
    // hit onward pull from behind
    assign cell_ctrl[i].load_left  = commit && (req_r == REQ_INSERT) && !full;
    assign cell_ctrl[i].load_right = commit && (req_r == REQ_DELETE) && any_hit
                                     && !before_first[i];
    assign cell_ctrl[i].cmp        = (state_r == S_CMP);

    blfid_cell u_cell (
      .clk        (clk),
      .ctrl       (cell_ctrl[i]),
      .active     (cell_active[i]),
      .value      (value_r),
      .left_data  (left_d),
      .right_data (right_d),
      .data       (cell_data[i]),
      .hit        (hit_vec[i])
    );
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    commit    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        state_nxt = S_UPD;
      end
      S_UPD: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          commit    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // result of the request under commit
  always_comb begin
    res_status = ST_OK;
    res_found  = 1'b0;
    cnt_nxt    = cnt_r;
    case (req_r) inside
      REQ_INSERT: begin
        if (full) begin
          res_status = ST_FULL;
        end else begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      REQ_DELETE, REQ_SEARCH: begin
        if (empty) begin
          res_status = ST_EMPTY;
        end else if (!any_hit) begin
          res_status = ST_NOMATCH;
        end else begin
          res_found = 1'b1;
          if (req_r == REQ_DELETE) begin
            cnt_nxt = cnt_r - CW'(1);
          end
        end
      end
      default: begin
        // unused request code: no change, status ok
        res_status = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (commit) begin
        cnt_r       <= cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    // payload: capture the request beat and the result
    if (in_valid && in_ready) begin
      req_r   <= in_req_type;
      value_r <= in_value;
    end
    if (commit) begin
      out_status_r <= res_status;
      out_found_r  <= res_found;
      out_cnt_r    <= cnt_nxt;
    end
  end

  assign cnt_ext         = EW'(out_cnt_r);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found       = out_found_r;
  assign out_entry_count = cnt_ext[4:0];

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_hit_inside: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPD) |-> ((hit_vec & ~cell_active) == '0))
    else $error("hit reported by a cell outside the list");

  a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && (req_r == REQ_INSERT) && full) |=> $stable(cnt_r))
    else $error("count changed on insert into full list");

  a_del_count: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && (req_r == REQ_DELETE) && any_hit && !empty)
      |=> (cnt_r == $past(cnt_r) - CW'(1)))
    else $error("delete with hit did not drop the count by one");

  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_found_r) |-> (out_status_r == ST_OK))
    else $error("found flag with non-ok status");
`endif

endmodule

>>> sim/tb_bounded_list_front_insert_delete.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bounded_list_front_insert_delete: self-checking bench for the front list
// Walks a short table of directed requests, then a long run of random
// requests biased to fill and drain the list. A queue-based copy of the
// list predicts each result beat, and random idling on both channels
// exercises the handshakes.
// ----------------------------------------------------------------------------
module tb_bounded_list_front_insert_delete;
  import blfid_pkg::*;

  localparam int          CLK_PERIOD   = 8;
  localparam int          RESET_CYCLES = 7;
  localparam int          CAPACITY     = CAPACITY_DEF;
  localparam int          RANDOM_ITEMS = 950;
  localparam int          MAX_GAP      = 17;
  localparam int          TAIL_CYCLES  = 12;
  localparam int          STALL_LIMIT  = 2000;
  // the one request code the block leaves unused; it must be ignored
  localparam logic [1:0]  REQ_UNUSED   = 2'd3;
  localparam logic [31:0] VAL_MIN      = 32'h8000_0000;
  localparam logic [31:0] VAL_MAX      = 32'h7fff_ffff;
  localparam logic [31:0] VAL_ONES     = 32'hffff_ffff;

  typedef struct packed {
    logic [1:0] status;
    logic       found;
    logic [4:0] count;
  } list_result_t;

  typedef struct {
    logic [1:0]   req;
    logic [31:0]  value;
    bit           typed;   // exp holds a hand-written result
    list_result_t exp;
  } dir_row_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [1:0]               in_req_type = REQ_INSERT;
  logic signed [DATA_W-1:0] in_value = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [1:0]               out_status;
  logic                     out_found;
  logic [4:0]               out_entry_count;

  // predicted list contents, index 0 is the front
  logic [31:0]  model_list[$];
  // results owed by the block, oldest first
  list_result_t pending_results[$];
  dir_row_t     dir_rows[$];

  int  errors       = 0;
  int  results_seen = 0;
  int  idle_cycles  = 0;
  int  n_by_req[4];
  int  n_by_status[4];
  int  n_del_hit    = 0;
  int  n_srch_hit   = 0;
  bit  tx_burst     = 1'b0;
  bit  rx_burst     = 1'b0;

  bounded_list_front_insert_delete #(
    .CAPACITY (CAPACITY)
  ) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_found       (out_found),
    .out_entry_count (out_entry_count)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Apply one request to the predicted list and return the result it owes.
  function automatic list_result_t apply_request(input logic [1:0] req,
                                                 input logic [31:0] v);
    list_result_t r;
    int           hit;
    r   = '0;
    hit = -1;
    if (req == REQ_INSERT) begin
      if (model_list.size() >= CAPACITY) r.status = ST_FULL;
      else model_list.push_front(v);
    end else if (req == REQ_DELETE || req == REQ_SEARCH) begin
      if (model_list.size() == 0) begin
        r.status = ST_EMPTY;
      end else begin
        // first match counting from the front
        for (int i = 0; i < model_list.size(); i++)
          if (hit < 0 && model_list[i] == v) hit = i;
        if (hit < 0) begin
          r.status = ST_NOMATCH;
        end else begin
          r.found = 1'b1;
          if (req == REQ_DELETE) model_list.delete(hit);
        end
      end
    end
    // an unused code falls through: ok, not found, count unchanged
    r.count = 5'(model_list.size());
    return r;
  endfunction

  function automatic int draw_gap(input bit burst);
    return burst ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  task automatic report_mismatch(input string field, input int unsigned got,
                                 input int unsigned want);
    $display("[%0t] mismatch on result %0d: %s got 0x%0h, expected 0x%0h",
             $time, results_seen, field, got, want);
    errors++;
  endtask

  task automatic add_row(input logic [1:0] req, input logic [31:0] value,
                         input bit typed, input logic [1:0] st,
                         input logic fnd, input logic [4:0] cnt);
    dir_row_t row;
    row.req   = req;
    row.value = value;
    row.typed = typed;
    row.exp   = '{status: st, found: fnd, count: cnt};
    dir_rows.push_back(row);
  endtask

  // Drive one request beat. Called just after a falling edge; returns just
  // after the falling edge that follows acceptance.
  task automatic send_req(input logic [1:0] req, input logic [31:0] v,
                          input bit typed, input list_result_t typed_exp);
    int           gap;
    list_result_t predicted;
    gap = draw_gap(tx_burst);
    // idle: drop valid only when a gap is drawn, so back-to-back beats
    // keep valid high without a glitch
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    = 1'b1;
    in_req_type = req;
    in_value    = v;
    // hold the beat until the block takes it
    do @(posedge clk); while (!in_ready);
    predicted = apply_request(req, v);
    pending_results.push_back(typed ? typed_exp : predicted);
    n_by_req[req]++;
    n_by_status[predicted.status]++;
    if (predicted.found && req == REQ_DELETE) n_del_hit++;
    if (predicted.found && req == REQ_SEARCH) n_srch_hit++;
    @(negedge clk);
    if ($urandom_range(0, 39) == 0) tx_burst = ~tx_burst;
  endtask

  // Check every result beat against the oldest owed result.
  always @(posedge clk) begin : result_check
    list_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected beat, status", out_status, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status)
          report_mismatch("status", out_status, want.status);
        if (out_found !== want.found)
          report_mismatch("found", out_found, want.found);
        if (out_entry_count !== want.count)
          report_mismatch("entry_count", out_entry_count, want.count);
      end
      results_seen++;
    end
  end

  // Watchdog: end the run when neither channel moves a beat for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("[%0t] no beat for %0d cycles, %0d results owed", $time,
               STALL_LIMIT, pending_results.size());
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: stall a random number of cycles before each beat.
  initial begin : result_sink
    int stall;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      stall = draw_gap(rx_burst);
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
      if ($urandom_range(0, 39) == 0) rx_burst = ~rx_burst;
    end
  end

  initial begin : stimulus
    logic [1:0]   req;
    logic [31:0]  v;
    int           pick;
    int           k;
    bit           fill_bias;
    list_result_t none;
    none      = '0;
    fill_bias = 1'b1;
    foreach (n_by_req[i]) n_by_req[i] = 0;
    foreach (n_by_status[i]) n_by_status[i] = 0;

    // Directed table. Typed rows carry the result read straight off the
    // behavior; the rest go to the predictor.
    add_row(REQ_SEARCH, 32'd0,   1, ST_EMPTY,   1'b0, 5'd0);  // search empty list
    add_row(REQ_DELETE, 32'd0,   1, ST_EMPTY,   1'b0, 5'd0);  // delete from empty list
    add_row(REQ_UNUSED, VAL_ONES, 1, ST_OK,     1'b0, 5'd0);  // unused code ignored
    add_row(REQ_INSERT, VAL_MIN, 1, ST_OK,      1'b0, 5'd1);
    add_row(REQ_INSERT, VAL_MAX, 1, ST_OK,      1'b0, 5'd2);
    add_row(REQ_SEARCH, VAL_MAX, 1, ST_OK,      1'b1, 5'd2);  // search hit
    add_row(REQ_SEARCH, 32'd0,   1, ST_NOMATCH, 1'b0, 5'd2);  // search miss
    add_row(REQ_DELETE, VAL_ONES, 1, ST_NOMATCH, 1'b0, 5'd2); // delete miss
    add_row(REQ_DELETE, VAL_MIN, 1, ST_OK,      1'b1, 5'd1);  // delete hit
    // fill to capacity with repeated values so deletes later pick the front one
    for (int i = 0; i < CAPACITY - 1; i++)
      add_row(REQ_INSERT, 32'(i % 5), 0, ST_OK, 1'b0, 5'd0);
    add_row(REQ_INSERT, VAL_ONES, 1, ST_FULL,   1'b0, 5'(CAPACITY));  // full list
    add_row(REQ_DELETE, 32'd2,   0, ST_OK,      1'b0, 5'd0);  // first of duplicates
    add_row(REQ_UNUSED, 32'd0,   1, ST_OK,      1'b0, 5'(CAPACITY - 1));

    // hold reset for a fixed count, release at a falling edge
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_rows[i])
      send_req(dir_rows[i].req, dir_rows[i].value, dir_rows[i].typed,
               dir_rows[i].exp);

    // Random part: every 120 requests pick a fill-biased or drain-biased phase
    // at random so the list swings between empty and full; about half the
    // values come from the current contents so deletes and searches hit.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 120 == 0) fill_bias = $urandom_range(0, 1);
      pick = $urandom_range(0, 99);
      if (fill_bias)
        req = (pick < 60) ? REQ_INSERT : (pick < 80) ? REQ_DELETE :
              (pick < 96) ? REQ_SEARCH : REQ_UNUSED;
      else
        req = (pick < 30) ? REQ_INSERT : (pick < 65) ? REQ_DELETE :
              (pick < 96) ? REQ_SEARCH : REQ_UNUSED;
      k = $urandom_range(0, 3);
      if (k < 2 && model_list.size() > 0) begin
        v = model_list[$urandom_range(0, model_list.size() - 1)];
      end else if (k < 3) begin
        k = $urandom_range(0, 10);
        v = (k < 8) ? 32'(k) : (k == 8) ? VAL_MIN : (k == 9) ? VAL_MAX : VAL_ONES;
      end else begin
        v = $urandom();
      end
      send_req(req, v, 0, none);
    end

    in_valid = 1'b0;
    // drain: wait for every owed result, then let the pipeline settle
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d requests: %0d insert, %0d delete, %0d search, %0d unused code",
             n_by_req[REQ_INSERT] + n_by_req[REQ_DELETE] + n_by_req[REQ_SEARCH] +
             n_by_req[REQ_UNUSED], n_by_req[REQ_INSERT], n_by_req[REQ_DELETE],
             n_by_req[REQ_SEARCH], n_by_req[REQ_UNUSED]);
    $display("Outcomes: %0d full, %0d empty, %0d no match, %0d removed, %0d found",
             n_by_status[ST_FULL], n_by_status[ST_EMPTY], n_by_status[ST_NOMATCH],
             n_del_hit, n_srch_hit);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches over %0d result beats", errors, results_seen);
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/blfid_pkg.sv
design/blfid_cell.sv
design/bounded_list_front_insert_delete.sv
sim/tb_bounded_list_front_insert_delete.sv
